[rtl/tbpf_pkg.sv]
package tbpf_pkg;

  // Video memory geometry. The tile map window 0x9800..0x9fff lands on the
  // top 2 KiB of the 13-bit address space; tile rows are byte pairs at an
  // even address, so the bit planes split into an even and an odd bank.
  localparam int VRAM_BYTES      = 8192;
  localparam int VRAM_AW         = $clog2(VRAM_BYTES);
  localparam int MAP_DEPTH       = 2048;
  localparam int MAP_AW          = $clog2(MAP_DEPTH);
  localparam int PLANE_DEPTH     = VRAM_BYTES / 2;
  localparam int PLANE_AW        = $clog2(PLANE_DEPTH);
  localparam int SCREEN_WIDTH_DEF = 160;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_AW      = 5;
  localparam int CFG_DW      = 32;

  // Item kind carried on in_tuser.
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_RENDER = 1'b1;

  // Register indexes (byte address 4 * index).
  typedef enum logic [2:0] {
    REG_SCROLL_X     = 3'd0,
    REG_SCROLL_Y     = 3'd1,
    REG_BG_PALETTE   = 3'd2,
    REG_MAP_SEL      = 3'd3,
    REG_TILE_DATA_SEL = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] scroll_x;
    logic [7:0] scroll_y;
    logic [7:0] bg_palette;
    logic       map_select;
    logic       tile_data_select;
  } cfg_t;

endpackage

[rtl/tbpf_ram.sv]
module tbpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read in the same cycle as a write to the same entry returns the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/tbpf_cfg_regs.sv]
module tbpf_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tbpf_pkg::CFG_AW-1:0] paddr,
  input  logic [tbpf_pkg::CFG_DW-1:0] pwdata,
  output logic [tbpf_pkg::CFG_DW-1:0] prdata,
  output tbpf_pkg::cfg_t              cfg
);

  import tbpf_pkg::*;

  logic [7:0] scroll_x_r;
  logic [7:0] scroll_y_r;
  logic [7:0] bg_palette_r;
  logic       map_select_r;
  logic       tile_data_select_r;
  reg_idx_t   idx;
  logic       wr_en;

  assign idx   = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_x_r         <= '0;
      scroll_y_r         <= '0;
      bg_palette_r       <= '0;
      map_select_r       <= 1'b0;
      tile_data_select_r <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_SCROLL_X:      scroll_x_r         <= pwdata[7:0];
        REG_SCROLL_Y:      scroll_y_r         <= pwdata[7:0];
        REG_BG_PALETTE:    bg_palette_r       <= pwdata[7:0];
        REG_MAP_SEL:       map_select_r       <= pwdata[0];
        REG_TILE_DATA_SEL: tile_data_select_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SCROLL_X:      prdata = {{(CFG_DW-8){1'b0}}, scroll_x_r};
      REG_SCROLL_Y:      prdata = {{(CFG_DW-8){1'b0}}, scroll_y_r};
      REG_BG_PALETTE:    prdata = {{(CFG_DW-8){1'b0}}, bg_palette_r};
      REG_MAP_SEL:       prdata = {{(CFG_DW-1){1'b0}}, map_select_r};
      REG_TILE_DATA_SEL: prdata = {{(CFG_DW-1){1'b0}}, tile_data_select_r};
      default:           prdata = '0;
    endcase
  end

  assign cfg.scroll_x         = scroll_x_r;
  assign cfg.scroll_y         = scroll_y_r;
  assign cfg.bg_palette       = bg_palette_r;
  assign cfg.map_select       = map_select_r;
  assign cfg.tile_data_select = tile_data_select_r;

endmodule

[rtl/tbpf_pixel_out.sv]
module tbpf_pixel_out (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       load,
  input  logic [7:0] plane_lo,
  input  logic [7:0] plane_hi,
  input  logic [2:0] fine_x,
  input  logic [7:0] bg_palette,
  input  logic [7:0] x_in,
  input  logic [7:0] line_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] shade,
  output logic [7:0] out_x,
  output logic [7:0] out_line
);

  logic       valid_r;
  logic [1:0] shade_r;
  logic [7:0] x_r;
  logic [7:0] line_r;
  logic [2:0] bit_sel;
  logic [1:0] pix;
  logic [7:0] pal_shift;
  logic [1:0] shade_nxt;

  // Leftmost pixel is bit 7 of each plane.
  assign bit_sel   = ~fine_x;
  assign pix       = {plane_hi[bit_sel], plane_lo[bit_sel]};
  assign pal_shift = bg_palette >> {pix, 1'b0};
  assign shade_nxt = pal_shift[1:0];

  assign load = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      shade_r <= shade_nxt;
      x_r     <= x_in;
      line_r  <= line_in;
    end
  end

  assign out_valid = valid_r;
  assign shade     = shade_r;
  assign out_x     = x_r;
  assign out_line  = line_r;

endmodule

[rtl/tile_background_pixel_fetch.sv]
// Render items pass through the stage 1 and stage 2 registers and the output register.
// Throughput is one item per cycle unless out_tready stalls it, writes and renders
// alike; the tile map bank and the even and odd bit-plane banks each take one read
// per cycle. Reset clears the configuration registers and the pipeline valid bits
// only; the video memory banks are not cleared and hold anything until written.
module tile_background_pixel_fetch #(
  parameter int SCREEN_WIDTH = tbpf_pkg::SCREEN_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream. tdata, from bit 0 up: mem_address[12:0], mem_data[20:13],
  // screen_x[28:21], screen_line[36:29], zero fill [39:37].
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [tbpf_pkg::IN_TDATA_W-1:0]  in_tdata,
  // tuser, bit 0: action (0 memory write, 1 render).
  input  logic                             in_tuser,
  // Result stream. tdata, from bit 0 up: shade[1:0], out_x[9:2],
  // out_line[17:10], zero fill [23:18].
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tbpf_pkg::OUT_TDATA_W-1:0] out_tdata,
  // Configuration port.
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [tbpf_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [tbpf_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic [tbpf_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                             cfg_pready
);

  import tbpf_pkg::*;

  cfg_t cfg;

  tbpf_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  assign cfg_pready = 1'b1;

  // Unpack the input item.
  logic [VRAM_AW-1:0] mem_address;
  logic [7:0]         mem_data;
  logic [7:0]         screen_x;
  logic [7:0]         screen_line;

  assign mem_address = in_tdata[12:0];
  assign mem_data    = in_tdata[20:13];
  assign screen_x    = in_tdata[28:21];
  assign screen_line = in_tdata[36:29];

  // Pipeline stage enables. Each stage loads when it is empty or when the
  // stage after it moves on, so bubbles (writes, off-screen columns) close up
  // and new items keep entering while a finished result waits.
  logic v1_r;
  logic v2_r;
  logic en1;
  logic en2;
  logic en3;
  logic in_accept;

  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;
  assign in_accept = in_tvalid && en1;

  logic is_render;
  logic is_write;
  logic on_screen;

  assign is_render = in_tuser == ACT_RENDER;
  assign is_write  = in_tuser == ACT_WRITE;
  assign on_screen = {1'b0, screen_x} < 9'(SCREEN_WIDTH);

  // Stage 0: scroll with 8-bit wraparound and address the tile map.
  logic [7:0] px;
  logic [7:0] py;

  assign px = screen_x + cfg.scroll_x;
  assign py = screen_line + cfg.scroll_y;

  // Writes go to every bank that covers the address. The map bank mirrors
  // the window 0x1800..0x1fff; even and odd bytes land in their plane banks.
  logic              map_we;
  logic              even_we;
  logic              odd_we;
  logic [MAP_AW-1:0] map_raddr;
  logic [7:0]        tile_num;

  assign map_we    = in_accept && is_write && (mem_address[VRAM_AW-1:MAP_AW] == 2'b11);
  assign even_we   = in_accept && is_write && !mem_address[0];
  assign odd_we    = in_accept && is_write && mem_address[0];
  assign map_raddr = {cfg.map_select, py[7:3], px[7:3]};

  tbpf_ram #(
    .WIDTH (8),
    .DEPTH (MAP_DEPTH)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (mem_address[MAP_AW-1:0]),
    .wdata (mem_data),
    .re    (en1),
    .raddr (map_raddr),
    .rdata (tile_num)
  );

  // Stage 1 registers travel beside the map read.
  logic [2:0] s1_fine_x_r;
  logic [2:0] s1_row_r;
  logic [7:0] s1_x_r;
  logic [7:0] s1_line_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_accept && is_render && on_screen;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_fine_x_r <= px[2:0];
      s1_row_r    <= py[2:0];
      s1_x_r      <= screen_x;
      s1_line_r   <= screen_line;
    end
  end

  // Stage 1: tile row address. The row always starts at an even byte, so
  // the low plane sits in the even bank and the high plane in the odd bank
  // at the same word index. Bit 12 is set only for signed tiles 0..127,
  // which lie at 0x9000 and up; signed tiles 128..255 fall to 0x8800.
  logic                row_top;
  logic [PLANE_AW-1:0] plane_raddr;
  logic [7:0]          plane_lo;
  logic [7:0]          plane_hi;

  assign row_top     = !cfg.tile_data_select && !tile_num[7];
  assign plane_raddr = {row_top, tile_num, s1_row_r};

  tbpf_ram #(
    .WIDTH (8),
    .DEPTH (PLANE_DEPTH)
  ) u_even_ram (
    .clk   (clk),
    .we    (even_we),
    .waddr (mem_address[VRAM_AW-1:1]),
    .wdata (mem_data),
    .re    (en2),
    .raddr (plane_raddr),
    .rdata (plane_lo)
  );

  tbpf_ram #(
    .WIDTH (8),
    .DEPTH (PLANE_DEPTH)
  ) u_odd_ram (
    .clk   (clk),
    .we    (odd_we),
    .waddr (mem_address[VRAM_AW-1:1]),
    .wdata (mem_data),
    .re    (en2),
    .raddr (plane_raddr),
    .rdata (plane_hi)
  );

  // Stage 2 registers travel beside the plane reads. A write accepted in the
  // same cycle as a plane read is younger than that render, and the banks
  // return the old byte, so no forwarding is needed.
  logic [2:0] s2_fine_x_r;
  logic [7:0] s2_x_r;
  logic [7:0] s2_line_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_fine_x_r <= s1_fine_x_r;
      s2_x_r      <= s1_x_r;
      s2_line_r   <= s1_line_r;
    end
  end

  // Stage 2: pixel pick, palette map and the output register.
  logic [1:0] shade;
  logic [7:0] out_x;
  logic [7:0] out_line;

  tbpf_pixel_out u_pix (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (v2_r),
    .load       (en3),
    .plane_lo   (plane_lo),
    .plane_hi   (plane_hi),
    .fine_x     (s2_fine_x_r),
    .bg_palette (cfg.bg_palette),
    .x_in       (s2_x_r),
    .line_in    (s2_line_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .shade      (shade),
    .out_x      (out_x),
    .out_line   (out_line)
  );

  assign out_tdata = {6'b0, out_line, out_x, shade};

endmodule
